FILE: src/fmp_pkg.sv
`timescale 1ns / 1ps

package fmp_pkg;

  localparam int MAX_ITEMS_DEF = 1024;
  localparam int VALUE_W       = 32;
  localparam int MISSING_W     = 11;
  localparam int IN_TDATA_W    = 32;
  localparam int OUT_TDATA_W   = 16;

  // Controller to datapath
  typedef struct packed {
    logic load_en;     // accept one element this cycle
    logic sweep_step;  // read and clear one bitmap entry, advance the address
    logic scan_mode;   // sweep belongs to a list end, evaluate its read data
    logic out_load;    // load the result register and reset the list state
  } fmp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sweep_last;  // sweep address sits on the last bitmap entry
    logic out_free;    // result register can take a new request
  } fmp_stat_t;

endpackage

FILE: src/fmp_ctrl.sv
`timescale 1ns / 1ps

module fmp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tlast,
  input  fmp_pkg::fmp_stat_t stat,
  output logic              in_tready,
  output fmp_pkg::fmp_cmd_t  cmd
);
  import fmp_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_PUSH  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    in_tready      = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        in_tready   = 1'b1;
        cmd.load_en = in_tvalid;
        if (in_tvalid && in_tlast) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.sweep_step = 1'b1;
        cmd.scan_mode  = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        // hold the answer until the result register frees up
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_tready_only_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (state_r == ST_LOAD))
    else $error("in_tready outside of load state");

  a_last_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> (state_r == ST_SCAN))
    else $error("list end did not start the scan");

  a_drain_to_push: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |=> (state_r == ST_PUSH))
    else $error("drain did not advance to push");
`endif

endmodule

FILE: src/fmp_datapath.sv
`timescale 1ns / 1ps

module fmp_datapath #(
  parameter int MAX_ITEMS = fmp_pkg::MAX_ITEMS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fmp_pkg::fmp_cmd_t                 cmd,
  input  logic [fmp_pkg::VALUE_W-1:0]       in_value,
  input  logic                              out_tready,
  output fmp_pkg::fmp_stat_t                stat,
  output logic                              out_tvalid,
  output logic [fmp_pkg::MISSING_W-1:0]     out_missing,
  output logic                              out_overflow
);
  import fmp_pkg::*;

  localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int AW = $clog2(MAX_ITEMS + 2);
  localparam int MW = (AW > MISSING_W) ? AW : MISSING_W;

  logic          seen_mem [MAX_ITEMS];
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic          mem_wbit;
  logic          rd_bit_r;
  logic          rd_valid_r;
  logic [IW-1:0] rd_idx_r;

  logic [IW-1:0] sweep_addr_r;
  logic [CW-1:0] count_r;
  logic          drop_r;
  logic          found_r;
  logic [MW-1:0] answer_r;

  logic          out_valid_r;
  logic [MISSING_W-1:0] out_missing_r;
  logic          out_ovf_r;

  logic          count_full;
  logic          value_hit;
  logic [VALUE_W-1:0] value_m1;
  logic [MW-1:0] final_ans;

  assign count_full = (count_r == CW'(MAX_ITEMS));
  assign value_hit  = !in_value[VALUE_W-1] && (in_value != '0)
                      && (in_value <= VALUE_W'(MAX_ITEMS));
  assign value_m1   = in_value - VALUE_W'(1);

  assign stat.sweep_last = (sweep_addr_r == IW'(MAX_ITEMS - 1));
  assign stat.out_free   = !out_valid_r || out_tready;

  // one write port: set on load, clear on sweep
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_addr_r;
    mem_wbit  = 1'b0;
    if (cmd.load_en && !count_full && value_hit) begin
      mem_we    = 1'b1;
      mem_waddr = value_m1[IW-1:0];
      mem_wbit  = 1'b1;
    end else if (cmd.sweep_step) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      seen_mem[mem_waddr] <= mem_wbit;
    end
    rd_bit_r <= seen_mem[sweep_addr_r];
    rd_idx_r <= sweep_addr_r;
  end

  assign final_ans = found_r ? answer_r : (MW'(count_r) + MW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_addr_r <= '0;
      rd_valid_r   <= 1'b0;
      count_r      <= '0;
      drop_r       <= 1'b0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      rd_valid_r <= cmd.sweep_step && cmd.scan_mode;
      if (cmd.sweep_step) begin
        sweep_addr_r <= stat.sweep_last ? '0 : sweep_addr_r + IW'(1);
      end
      if (cmd.load_en) begin
        if (count_full) begin
          drop_r <= 1'b1;
        end else begin
          count_r <= count_r + CW'(1);
        end
      end
      // first clear bit below the list length gives the answer
      if (rd_valid_r && !found_r && !rd_bit_r && (CW'(rd_idx_r) < count_r)) begin
        found_r <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
        count_r     <= '0;
        drop_r      <= 1'b0;
        found_r     <= 1'b0;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid_r && !found_r) begin
      answer_r <= MW'(rd_idx_r) + MW'(1);
    end
    if (cmd.out_load) begin
      out_missing_r <= final_ans[MISSING_W-1:0];
      out_ovf_r     <= drop_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_missing  = out_missing_r;
  assign out_overflow = out_ovf_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ITEMS))
    else $error("item count beyond capacity");

  a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load_en && cmd.sweep_step))
    else $error("load and sweep on the bitmap port together");

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result loaded over a pending request");

  a_list_reset: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (count_r == '0 && !drop_r && !found_r && out_valid_r))
    else $error("list state not reset after result");
`endif

endmodule

FILE: src/first_missing_positive_top.sv
`timescale 1ns / 1ps
// Channel  Dir  Payload                                      Handshake
// in_      in   tdata[31:0] value (signed), tlast last       tvalid/tready
// out_     out  tdata[10:0] missing, tuser[0] overflow       tvalid/tready
//
// Elements load at one per cycle while in_tready is high, into a 1-bit presence bitmap memory.
// At a list end, one bitmap entry per cycle is read and cleared through the
// single memory port, then a drain state checks the last read entry and a
// push state loads the result once the output register is free.
// After reset a clearing pass over every bitmap entry runs before in_tready rises.
// A stalled result holds in the output register; the next list loads behind
// it, and only its own list end waits for that register to empty.
module first_missing_positive_top #(
  parameter int MAX_ITEMS = fmp_pkg::MAX_ITEMS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [fmp_pkg::IN_TDATA_W-1:0]      in_tdata,   // [31:0] value
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [fmp_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [10:0] missing, rest zero
  output logic                                out_tuser   // [0] overflow
);
  import fmp_pkg::*;

  fmp_cmd_t  cmd;
  fmp_stat_t stat;
  logic [MISSING_W-1:0] missing;

  fmp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .stat      (stat),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  fmp_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_value     (in_tdata[VALUE_W-1:0]),
    .out_tready   (out_tready),
    .stat         (stat),
    .out_tvalid   (out_tvalid),
    .out_missing  (missing),
    .out_overflow (out_tuser)
  );

  assign out_tdata = {{(OUT_TDATA_W - MISSING_W){1'b0}}, missing};

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int LIST_CAP = fmp_pkg::MAX_ITEMS_DEF;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
  } element_t;

  typedef struct packed {
    logic [fmp_pkg::MISSING_W-1:0] missing;
    logic                          overflow;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [fmp_pkg::IN_TDATA_W-1:0] in_tdata = '0;   // [31:0] value
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [fmp_pkg::OUT_TDATA_W-1:0] out_tdata;      // [10:0] missing, rest zero
  logic out_tuser;                                 // [0] overflow

  first_missing_positive_top #(
    .MAX_ITEMS(LIST_CAP)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  element_t elem_queue[$];
  answer_t  answer_queue[$];
  int       total_elems = 0;
  int       issued = 0;
  int       taken = 0;
  int       quiet_from = 32'h7FFF_FFFF;
  int       errors = 0;

  // Own copy of the list state
  bit seen_bits [1:LIST_CAP];
  int list_len = 0;
  bit list_dropped = 1'b0;

  function automatic logic [fmp_pkg::MISSING_W-1:0] lowest_absent(int n);
    for (int k = 1; k <= n && k <= LIST_CAP; k++) begin
      if (!seen_bits[k]) return k[fmp_pkg::MISSING_W-1:0];
    end
    return 11'(n + 1);
  endfunction

  task automatic take_element(element_t e);
    int v;
    answer_t a;
    v = signed'(e.value);
    if (list_len >= LIST_CAP) begin
      list_dropped = 1'b1;
    end else begin
      list_len++;
      if (v >= 1 && v <= LIST_CAP) seen_bits[v] = 1'b1;
    end
    if (e.last) begin
      a.missing = lowest_absent(list_len);
      a.overflow = list_dropped;
      answer_queue.insert(answer_queue.size(), a);
      foreach (seen_bits[k]) seen_bits[k] = 1'b0;
      list_len = 0;
      list_dropped = 1'b0;
    end
  endtask

  // Driver: hold a request until taken, idle in bursts between requests
  element_t cur_elem = '0;
  int       in_gap = 0;

  always @(posedge clk) begin : drive_elements
    logic nv;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        take_element(cur_elem);
        taken++;
      end
      if (in_tvalid && !in_tready) begin
        nv = 1'b1;
      end else if (in_gap > 0) begin
        in_gap--;
        nv = 1'b0;
      end else if (issued < quiet_from && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(0, 15);
        nv = 1'b0;
      end else if (elem_queue.size() > 0) begin
        cur_elem = elem_queue.pop_front();
        issued++;
        nv = 1'b1;
      end else begin
        nv = 1'b0;
      end
      in_tvalid <= nv;
      in_tdata  <= cur_elem.value;
      in_tlast  <= cur_elem.last;
    end
  end

  // Monitor: check each result, stall in bursts
  int out_stall = 0;

  always @(posedge clk) begin : check_answers
    answer_t want;
    logic nr;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (answer_queue.size() == 0) begin
          $display("%0t: unexpected result: missing %0d overflow %0b",
                   $time, out_tdata, out_tuser);
          errors++;
        end else begin
          want = answer_queue.pop_front();
          if (out_tdata !== {{(fmp_pkg::OUT_TDATA_W - fmp_pkg::MISSING_W){1'b0}},
                             want.missing}) begin
            $display("%0t: missing mismatch: expected %0d actual %0d",
                     $time, want.missing, out_tdata);
            errors++;
          end
          if (out_tuser !== want.overflow) begin
            $display("%0t: overflow mismatch: expected %0b actual %0b",
                     $time, want.overflow, out_tuser);
            errors++;
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        nr = 1'b0;
      end else if (issued < quiet_from && $urandom_range(0, 7) == 0) begin
        out_stall = $urandom_range(0, 15);
        nr = 1'b0;
      end else begin
        nr = 1'b1;
      end
      out_tready <= nr;
    end
  end

  task automatic push_elem(logic [31:0] value, logic last);
    element_t e;
    e.value = value;
    e.last = last;
    elem_queue.insert(elem_queue.size(), e);
    total_elems++;
  endtask

  function automatic logic [31:0] odd_value(int n);
    case ($urandom_range(0, 6))
      0: return 32'd0;
      1: return 32'(-int'($urandom_range(1, 1000)));
      2: return {1'b1, 31'($urandom)};
      3: return 32'($urandom_range(n + 1, LIST_CAP));
      4: return 32'($urandom_range(LIST_CAP + 1, 32'h7FFF_FFFF));
      5: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($urandom_range(1, n));
    endcase
  endfunction

  // flavor: 0 permutation with a few holes, 1 heavily mixed, 2 noise, 3 clean permutation
  task automatic push_list(int n, int flavor);
    logic [31:0] vals[$];
    int j;
    logic [31:0] tmp;
    for (int i = 1; i <= n; i++) vals.insert(vals.size(), 32'(i));
    case (flavor)
      0: repeat ($urandom_range(0, 2)) vals[$urandom_range(0, n - 1)] = odd_value(n);
      1: foreach (vals[i]) if ($urandom_range(0, 1) != 0) vals[i] = odd_value(n);
      2: foreach (vals[i]) vals[i] = $urandom;
      default: ;
    endcase
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = vals[i];
      vals[i] = vals[j];
      vals[j] = tmp;
    end
    foreach (vals[i]) push_elem(vals[i], i == n - 1);
  endtask

  initial begin : stimulus
    int n;
    // single elements
    push_elem(32'd1, 1'b1);
    push_elem(32'd0, 1'b1);
    // extremes of the signed range
    push_elem(32'h7FFF_FFFF, 1'b0);
    push_elem(32'h8000_0000, 1'b0);
    push_elem(32'hFFFF_FFFF, 1'b1);
    // complete list
    push_elem(32'd3, 1'b0);
    push_elem(32'd1, 1'b0);
    push_elem(32'd2, 1'b1);
    // duplicates, value above the length
    push_elem(32'd2, 1'b0);
    push_elem(32'd2, 1'b0);
    push_elem(32'd1, 1'b0);
    push_elem(32'd5, 1'b1);
    // top of the bitmap and just beyond it
    push_elem(32'(LIST_CAP), 1'b0);
    push_elem(32'(LIST_CAP + 1), 1'b0);
    push_elem(32'd1, 1'b1);
    // one is absent
    push_elem(32'd2, 1'b0);
    push_elem(32'd3, 1'b0);
    push_elem(32'd4, 1'b1);

    while (total_elems < 950) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 16);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: push_list(n, 0);
        4:          push_list(n, 3);
        5, 6:       push_list(n, 1);
        7, 8:       push_list(n, 2);
        default:    push_list(1, $urandom_range(0, 2));
      endcase
    end
    quiet_from = total_elems - 120;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (taken < total_elems || answer_queue.size() != 0) @(posedge clk);
    repeat (LIST_CAP + 16) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
